// ===== hw/rtl/wpe_pkg.sv =====
`timescale 1ns / 1ps
// shared types and constants for the wca pair energy block
// no dependencies
package wpe_pkg;

    localparam int COORD_W  = 24;
    localparam int BOX_W    = 23;
    localparam int SQ_W     = 32;
    localparam int CFG_W    = 32;
    localparam int IDX_W    = 3;
    localparam int QUO_W    = 27;
    localparam int DIV_STEPS = QUO_W;

    localparam logic [IDX_W-1:0] REG_BOX_LENGTH   = 3'd0;
    localparam logic [IDX_W-1:0] REG_SIGMA_SQ_POL = 3'd1;
    localparam logic [IDX_W-1:0] REG_CUTOFF_SQ_POL = 3'd2;
    localparam logic [IDX_W-1:0] REG_SIGMA_SQ_OTH = 3'd3;
    localparam logic [IDX_W-1:0] REG_CUTOFF_SQ_OTH = 3'd4;

    localparam logic [BOX_W-1:0] BOX_RESET    = 23'd256000;
    localparam logic [SQ_W-1:0]  SIG_POL_RST  = 32'd7503217;
    localparam logic [SQ_W-1:0]  CUT_POL_RST  = 32'd9437184;
    localparam logic [SQ_W-1:0]  SIG_OTH_RST  = 32'd1875804;
    localparam logic [SQ_W-1:0]  CUT_OTH_RST  = 32'd2359296;

    typedef struct packed {
        logic signed [COORD_W-1:0] first_x;
        logic signed [COORD_W-1:0] first_y;
        logic signed [COORD_W-1:0] first_z;
        logic signed [COORD_W-1:0] second_x;
        logic signed [COORD_W-1:0] second_y;
        logic signed [COORD_W-1:0] second_z;
        logic                      both_polymer;
        logic                      bonded_or_paired;
        logic                      two_apart_on_chain;
    } t_in_word;

    typedef struct packed {
        logic [31:0] energy;
        logic        saturated;
    } t_out_word;

    // per-pair status carried alongside the data
    typedef struct packed {
        logic kill;
        logic sat;
    } t_tag;

endpackage

// ===== hw/rtl/wpe_div.sv =====
`timescale 1ns / 1ps
// pipelined restoring divider: floor(num * 2^24 / den), one quotient bit per stage
// depends on wpe_pkg
module wpe_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  wpe_pkg::t_tag               i_tag,
    input  logic [wpe_pkg::SQ_W-1:0]    i_num,
    input  logic [wpe_pkg::SQ_W-1:0]    i_den,
    output logic                        o_valid,
    output wpe_pkg::t_tag               o_tag,
    output logic [wpe_pkg::QUO_W-1:0]   o_quo
);
    import wpe_pkg::*;

    logic                r_v    [DIV_STEPS];
    t_tag                r_tag  [DIV_STEPS];
    logic [SQ_W-1:0]     r_rem  [DIV_STEPS];
    logic [SQ_W-1:0]     r_den  [DIV_STEPS];
    logic [QUO_W-1:0]    r_low  [DIV_STEPS];
    logic [QUO_W-1:0]    r_quo  [DIV_STEPS];

    genvar s;
    generate
        for (s = 0; s < DIV_STEPS; s++) begin : g_step
            logic            v_in;
            t_tag            tag_in;
            logic [SQ_W-1:0] rem_in;
            logic [SQ_W-1:0] den_in;
            logic [QUO_W-1:0] low_in;
            logic [QUO_W-1:0] quo_in;
            logic [SQ_W:0]   trial;
            logic [SQ_W:0]   diff;
            logic            ge;
            logic [SQ_W-1:0] n_rem;

            if (s == 0) begin : g_first
                // upper dividend bits are below den whenever the quotient fits
                assign v_in   = i_valid;
                assign tag_in = i_tag;
                assign rem_in = {3'b000, i_num[SQ_W-1:3]};
                assign den_in = i_den;
                assign low_in = {i_num[2:0], 24'd0};
                assign quo_in = '0;
            end else begin : g_next
                assign v_in   = r_v[s-1];
                assign tag_in = r_tag[s-1];
                assign rem_in = r_rem[s-1];
                assign den_in = r_den[s-1];
                assign low_in = r_low[s-1];
                assign quo_in = r_quo[s-1];
            end

            always_comb begin
                trial = {rem_in, low_in[QUO_W-1]};
                diff  = trial - {1'b0, den_in};
                ge    = (trial >= {1'b0, den_in});
                n_rem = ge ? diff[SQ_W-1:0] : trial[SQ_W-1:0];
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v[s] <= 1'b0;
                end else if (i_en) begin
                    r_v[s] <= v_in;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_tag[s] <= tag_in;
                    r_rem[s] <= n_rem;
                    r_den[s] <= den_in;
                    r_low[s] <= {low_in[QUO_W-2:0], 1'b0};
                    r_quo[s] <= {quo_in[QUO_W-2:0], ge};
                end
            end
        end
    endgenerate

    assign o_valid = r_v[DIV_STEPS-1];
    assign o_tag   = r_tag[DIV_STEPS-1];
    assign o_quo   = r_quo[DIV_STEPS-1];

endmodule

// ===== hw/rtl/wca_pair_energy_top.sv =====
`timescale 1ns / 1ps
// wca pair energy: cut-and-shifted lennard-jones energy of one bead pair
// input accept to output valid passes 4 front stages, 27 divider stages, 3 power
// stages and 1 output register; throughput one word per cycle unless stalled
// the whole pipeline advances together and freezes while the output word is stalled
// reset: synchronous active low, clears valid bits and loads register defaults
module wca_pair_energy_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  wpe_pkg::t_in_word           i_in_word,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output wpe_pkg::t_out_word          o_out_word,
    input  logic                        i_cfg_we,
    input  logic [wpe_pkg::IDX_W-1:0]   i_cfg_idx,
    input  logic [wpe_pkg::CFG_W-1:0]   i_cfg_data
);
    import wpe_pkg::*;

    // configuration registers
    logic [BOX_W-1:0] r_box;
    logic [SQ_W-1:0]  r_sig_pol, r_cut_pol, r_sig_oth, r_cut_oth;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_box     <= BOX_RESET;
            r_sig_pol <= SIG_POL_RST;
            r_cut_pol <= CUT_POL_RST;
            r_sig_oth <= SIG_OTH_RST;
            r_cut_oth <= CUT_OTH_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_BOX_LENGTH:    r_box     <= i_cfg_data[BOX_W-1:0];
                REG_SIGMA_SQ_POL:  r_sig_pol <= i_cfg_data;
                REG_CUTOFF_SQ_POL: r_cut_pol <= i_cfg_data;
                REG_SIGMA_SQ_OTH:  r_sig_oth <= i_cfg_data;
                REG_CUTOFF_SQ_OTH: r_cut_oth <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // global advance: everything moves unless the output word is held
    logic en;
    assign en         = !o_out_valid || i_out_ready;
    assign o_in_ready = en;

    // stage 1: raw differences, parameter select, exclusion
    logic               r1_v;
    logic signed [24:0] r1_d [3];
    logic [SQ_W-1:0]    r1_sig, r1_cut;
    logic               r1_excl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r1_v <= 1'b0;
        else if (en)  r1_v <= i_in_valid;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_d[0] <= 25'(i_in_word.first_x) - 25'(i_in_word.second_x);
            r1_d[1] <= 25'(i_in_word.first_y) - 25'(i_in_word.second_y);
            r1_d[2] <= 25'(i_in_word.first_z) - 25'(i_in_word.second_z);
            r1_sig  <= i_in_word.both_polymer ? r_sig_pol : r_sig_oth;
            r1_cut  <= i_in_word.both_polymer ? r_cut_pol : r_cut_oth;
            // two apart only counts when both beads are polymer
            r1_excl <= i_in_word.bonded_or_paired
                       | (i_in_word.both_polymer & i_in_word.two_apart_on_chain);
        end
    end

    // stage 2: minimum image and magnitude; any axis at 2^16 or more is beyond cutoff
    logic               r2_v;
    logic [15:0]        r2_m [3];
    logic               r2_big;
    logic [SQ_W-1:0]    r2_sig, r2_cut;
    logic               r2_excl;

    logic signed [25:0] img  [3];
    logic [25:0]        mag  [3];
    logic signed [25:0] half_s, box_s;
    logic               big;

    always_comb begin
        half_s = signed'({4'b0000, r_box[BOX_W-1:1]});
        box_s  = signed'({3'b000, r_box});
        big    = 1'b0;
        for (int a = 0; a < 3; a++) begin
            img[a] = 26'(r1_d[a]);
            if (img[a] > half_s)
                img[a] = img[a] - box_s;
            else if (img[a] < -half_s)
                img[a] = img[a] + box_s;
            mag[a] = img[a][25] ? 26'(-img[a]) : 26'(img[a]);
            big    = big | (|mag[a][25:16]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r2_v <= 1'b0;
        else if (en)  r2_v <= r1_v;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int a = 0; a < 3; a++) r2_m[a] <= mag[a][15:0];
            r2_big  <= big;
            r2_sig  <= r1_sig;
            r2_cut  <= r1_cut;
            r2_excl <= r1_excl;
        end
    end

    // stage 3: per-axis squares
    logic               r3_v;
    logic [31:0]        r3_sq [3];
    logic               r3_big;
    logic [SQ_W-1:0]    r3_sig, r3_cut;
    logic               r3_excl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r3_v <= 1'b0;
        else if (en)  r3_v <= r2_v;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int a = 0; a < 3; a++) r3_sq[a] <= r2_m[a] * r2_m[a];
            r3_big  <= r2_big;
            r3_sig  <= r2_sig;
            r3_cut  <= r2_cut;
            r3_excl <= r2_excl;
        end
    end

    // stage 4: r2 sum, cutoff test, zero-distance and large-ratio checks
    logic               r4_v;
    logic [SQ_W-1:0]    r4_r2, r4_sig;
    t_tag               r4_tag;

    logic [33:0]        r2_sum;
    logic               outside, zero_d, big_ratio;

    always_comb begin
        r2_sum    = 34'(r3_sq[0]) + 34'(r3_sq[1]) + 34'(r3_sq[2]);
        outside   = r3_big || (r2_sum >= 34'(r3_cut));
        zero_d    = (r2_sum == '0);
        // sigma2 >= 8 * r2 means x of 8 or more: result far past the clamp
        big_ratio = ({3'b000, r3_sig} >= {r2_sum[31:0], 3'b000});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r4_v <= 1'b0;
        else if (en)  r4_v <= r3_v;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_r2      <= r2_sum[31:0];
            r4_sig     <= r3_sig;
            r4_tag.kill <= r3_excl | outside;
            r4_tag.sat  <= zero_d | big_ratio;
        end
    end

    // x = sigma2 * 2^24 / r2 in q.24
    logic               dv_v;
    t_tag               dv_tag;
    logic [QUO_W-1:0]   dv_x;

    wpe_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r4_v),
        .i_tag   (r4_tag),
        .i_num   (r4_sig),
        .i_den   (r4_r2),
        .o_valid (dv_v),
        .o_tag   (dv_tag),
        .o_quo   (dv_x)
    );

    // power stage a: x * x
    logic               ra_v;
    t_tag               ra_tag;
    logic [QUO_W-1:0]   ra_x;
    logic [53:0]        ra_xx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) ra_v <= 1'b0;
        else if (en)  ra_v <= dv_v;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            ra_tag <= dv_tag;
            ra_x   <= dv_x;
            ra_xx  <= dv_x * dv_x;
        end
    end

    // power stage b: x2 * x, x2 = floor(x*x / 2^24)
    logic               rb_v;
    t_tag               rb_tag;
    logic [56:0]        rb_xxx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) rb_v <= 1'b0;
        else if (en)  rb_v <= ra_v;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            rb_tag <= ra_tag;
            rb_xxx <= ra_xx[53:24] * ra_x;
        end
    end

    // power stage c: u = 2*x3 - 1.0 in q.24, magnitude and range check
    logic               rc_v;
    t_tag               rc_tag;
    logic [31:0]        rc_mag;
    logic               rc_ovf;

    logic signed [34:0] u_val;
    logic [34:0]        u_mag;

    always_comb begin
        u_val = signed'({1'b0, rb_xxx[56:24], 1'b0}) - signed'(35'd16777216);
        u_mag = u_val[34] ? 35'(-u_val) : 35'(u_val);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) rc_v <= 1'b0;
        else if (en)  rc_v <= rb_v;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            rc_tag <= rb_tag;
            rc_mag <= u_mag[31:0];
            rc_ovf <= |u_mag[34:32];
        end
    end

    // output register: u^2 / 2^32 in q16.16, with clamp and exclusion applied
    logic               r_ov;
    t_out_word          r_ow;
    logic [63:0]        sq_u;

    assign sq_u = rc_mag * rc_mag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ov <= 1'b0;
        else if (en)  r_ov <= rc_v;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (rc_tag.kill) begin
                r_ow.energy    <= '0;
                r_ow.saturated <= 1'b0;
            end else if (rc_tag.sat || rc_ovf) begin
                r_ow.energy    <= '1;
                r_ow.saturated <= 1'b1;
            end else begin
                r_ow.energy    <= sq_u[63:32];
                r_ow.saturated <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_ov;
    assign o_out_word  = r_ow;

    // a saturated word always carries the full-scale energy
    a_sat_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.saturated |-> o_out_word.energy == 32'hFFFF_FFFF)
        else $error("saturated word without full-scale energy");

    // a held output word freezes the input side
    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |-> !o_in_ready)
        else $error("input accepted while output stalled");

    // no words come out of the cycle right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule
